FILE: hdl/scope_capture_channel_macros.svh
// Assertion macros used by the scope capture channel checker.
`ifndef SCOPE_CAPTURE_CHANNEL_MACROS_SVH
`define SCOPE_CAPTURE_CHANNEL_MACROS_SVH

// Same-cycle implication under reset.
`define SCC_ASSERT_NOW(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error("assertion failed");

// Next-cycle implication under reset.
`define SCC_ASSERT_NEXT(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error("assertion failed");

`endif

FILE: hdl/scc_pkg.sv
// Types and constants of the scope capture channel.
package scc_pkg;

   typedef enum logic [2:0] {
      MODE_POLL  = 3'd0,
      MODE_BIND  = 3'd1,
      MODE_START = 3'd2,
      MODE_STOP  = 3'd3,
      MODE_CLEAR = 3'd4,
      MODE_SWAP  = 3'd5,
      MODE_READ  = 3'd6
   } mode_type;

   typedef enum logic [2:0] {
      TYPE_INT8   = 3'd0,
      TYPE_INT16  = 3'd1,
      TYPE_INT32  = 3'd2,
      TYPE_UINT8  = 3'd3,
      TYPE_UINT16 = 3'd4,
      TYPE_UINT32 = 3'd5,
      TYPE_FLOAT  = 3'd6
   } sample_kind_type;

   typedef enum logic [2:0] {
      ST_INIT    = 3'b001,
      ST_STOPPED = 3'b010,
      ST_RUNNING = 3'b100
   } chan_state_type;

   localparam logic [1:0] CODE_INIT    = 2'd0;
   localparam logic [1:0] CODE_STOPPED = 2'd1;
   localparam logic [1:0] CODE_RUNNING = 2'd2;

   localparam logic [2:0] SAMPLE_TYPE_RESET = 3'd6;

   // Transaction leaving the converter toward the ring control.
   typedef struct packed {
      logic        valid;
      mode_type    mode;
      logic [31:0] value;
   } conv_out_type;

endpackage

FILE: hdl/scc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
module scc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: hdl/scc_convert.sv
// Two-stage sample converter: raw word to IEEE single.
module scc_convert (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 take,
   input  logic [2:0]           mode,
   input  logic [31:0]          word,
   input  logic [2:0]           sample_type,
   output scc_pkg::conv_out_type conv_out
);
   import scc_pkg::*;

   // stage 1: sign, magnitude, leading-one position
   logic        s1_valid_ff, s1_valid_in;
   mode_type    s1_mode_ff;
   logic        s1_neg_ff, s1_neg_in;
   logic        s1_pass_ff, s1_pass_in;
   logic [31:0] s1_mag_ff, s1_mag_in;
   logic [4:0]  s1_pos_ff, s1_pos_in;
   conv_out_type s2_ff, s2_in;

   always_comb begin
      s1_neg_in  = 1'b0;
      s1_pass_in = 1'b0;
      s1_mag_in  = word;
      case (sample_kind_type'(sample_type))
         TYPE_INT8: begin
            s1_neg_in = word[7];
            s1_mag_in = word[7] ? (32'h100 - {24'b0, word[7:0]}) : {24'b0, word[7:0]};
         end
         TYPE_INT16: begin
            s1_neg_in = word[15];
            s1_mag_in = word[15] ? (32'h10000 - {16'b0, word[15:0]}) : {16'b0, word[15:0]};
         end
         TYPE_INT32: begin
            s1_neg_in = word[31];
            s1_mag_in = word[31] ? (32'd0 - word) : word;
         end
         TYPE_UINT8:  s1_mag_in = {24'b0, word[7:0]};
         TYPE_UINT16: s1_mag_in = {16'b0, word[15:0]};
         TYPE_UINT32: s1_mag_in = word;
         default:     s1_pass_in = 1'b1;
      endcase
      s1_pos_in = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (s1_mag_in[i]) begin
            s1_pos_in = 5'(i);
         end
      end
      s1_valid_in = advance ? take : s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_ff.valid <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_ff.valid <= s2_in.valid;
      end
      if (advance) begin
         s1_mode_ff  <= mode_type'(mode);
         s1_neg_ff   <= s1_neg_in;
         s1_pass_ff  <= s1_pass_in;
         s1_mag_ff   <= s1_mag_in;
         s1_pos_ff   <= s1_pos_in;
         s2_ff.mode  <= s2_in.mode;
         s2_ff.value <= s2_in.value;
      end
   end

   // stage 2: align, round to nearest even, pack
   always_comb begin
      logic [24:0] mant;
      logic [4:0]  sh;
      logic [31:0] rem, half;
      logic [7:0]  expf;
      logic [31:0] bits;
      mant = 25'd0;
      sh   = 5'd0;
      rem  = 32'd0;
      half = 32'd0;
      if (s1_pos_ff <= 5'd23) begin
         mant = 25'(s1_mag_ff << (5'd23 - s1_pos_ff));
      end else begin
         sh   = s1_pos_ff - 5'd23;
         mant = 25'(s1_mag_ff >> sh);
         rem  = s1_mag_ff & ((32'd1 << sh) - 32'd1);
         half = 32'd1 << (sh - 5'd1);
         if (rem > half || (rem == half && mant[0])) begin
            mant = mant + 25'd1;
         end
      end
      expf = 8'd126 + {3'b0, s1_pos_ff};
      bits = {1'b0, expf, 23'b0} + {7'b0, mant};
      if (s1_neg_ff) begin
         bits[31] = 1'b1;
      end
      if (s1_mag_ff == 32'd0) begin
         bits = 32'd0;
      end
      if (s1_pass_ff) begin
         bits = s1_mag_ff;
      end
      s2_in.valid = advance ? s1_valid_ff : s2_ff.valid;
      s2_in.mode  = s1_mode_ff;
      s2_in.value = bits;
   end

   assign conv_out = s2_ff;
endmodule

FILE: hdl/scc_ring_ctrl.sv
// Channel state, ping-pong ring pointers, ring memories and result register.
module scc_ring_ctrl #(
   parameter int CAPACITY = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  scc_pkg::conv_out_type conv_in,
   output logic                  out_valid,
   output logic                  out_accepted,
   output logic [31:0]           out_prev,
   output logic [31:0]           out_cur,
   output logic [31:0]           out_read_value,
   output logic                  out_read_valid,
   output logic                  out_swap_pending,
   output logic [10:0]           out_poll_fill,
   output logic [10:0]           out_swap_fill,
   output logic [1:0]            out_state
);
   import scc_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
   localparam logic [AW:0]   CAP_S  = (AW+1)'(CAPACITY);
   localparam logic [AW-1:0] LAST_A = AW'(CAPACITY - 1);

   chan_state_type state_ff, state_in;
   logic [31:0]    prev_ff, prev_in;
   logic           poll_b_ff, poll_b_in;
   logic [AW-1:0]  ph_ff, ph_in, sh_ff, sh_in;
   logic [CW-1:0]  pc_ff, pc_in, sc_ff, sc_in;

   logic           go;
   logic           wr_en, rd_en;
   logic [AW-1:0]  wr_addr;
   logic [AW:0]    sum;
   logic           accepted, rvalid;
   logic [31:0]    tprev, tcur;
   logic [31:0]    rd_a, rd_b;

   logic           ov_ff, acc_ff, rv_ff, rsel_ff, pend_ff;
   logic [31:0]    tp_ff, tc_ff;
   logic [10:0]    pf_ff, sf_ff;
   logic [1:0]     st_ff, st_code;

   assign go = advance && conv_in.valid;

   always_comb begin
      state_in  = state_ff;
      prev_in   = prev_ff;
      poll_b_in = poll_b_ff;
      ph_in     = ph_ff;
      pc_in     = pc_ff;
      sh_in     = sh_ff;
      sc_in     = sc_ff;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      accepted  = 1'b0;
      rvalid    = 1'b0;
      tprev     = 32'd0;
      tcur      = 32'd0;
      sum       = (AW+1)'(ph_ff) + (AW+1)'(pc_ff);
      if (sum >= CAP_S) begin
         sum = sum - CAP_S;
      end
      wr_addr = sum[AW-1:0];
      if (go) begin
         case (conv_in.mode)
            MODE_POLL: begin
               if (state_ff == ST_RUNNING) begin
                  accepted = 1'b1;
                  tprev    = prev_ff;
                  tcur     = conv_in.value;
                  prev_in  = conv_in.value;
                  wr_en    = 1'b1;
                  if (pc_ff >= CAP_C) begin
                     // full: overwrite the oldest entry and advance the head
                     wr_addr = ph_ff;
                     ph_in   = (ph_ff == LAST_A) ? '0 : ph_ff + 1'b1;
                  end else begin
                     pc_in = pc_ff + 1'b1;
                  end
               end
            end
            MODE_BIND: begin
               if (state_ff == ST_INIT) begin
                  state_in = ST_STOPPED;
               end
            end
            MODE_START: begin
               if (state_ff == ST_STOPPED) begin
                  state_in = ST_RUNNING;
                  accepted = 1'b1;
               end
            end
            MODE_STOP: begin
               if (state_ff == ST_RUNNING) begin
                  state_in = ST_STOPPED;
                  accepted = 1'b1;
               end
            end
            MODE_CLEAR: begin
               ph_in = '0;
               pc_in = '0;
               sh_in = '0;
               sc_in = '0;
            end
            MODE_SWAP: begin
               poll_b_in = ~poll_b_ff;
               sh_in     = ph_ff;
               sc_in     = pc_ff;
               ph_in     = '0;
               pc_in     = '0;
            end
            MODE_READ: begin
               if (sc_ff != '0) begin
                  rd_en  = 1'b1;
                  rvalid = 1'b1;
                  sh_in  = (sh_ff == LAST_A) ? '0 : sh_ff + 1'b1;
                  sc_in  = sc_ff - 1'b1;
               end
            end
            default: ;
         endcase
      end
      case (state_in)
         ST_INIT:    st_code = CODE_INIT;
         ST_STOPPED: st_code = CODE_STOPPED;
         ST_RUNNING: st_code = CODE_RUNNING;
         default:    st_code = CODE_INIT;
      endcase
   end

   scc_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_en && !poll_b_ff),
      .wr_addr (wr_addr),
      .wr_data (conv_in.value),
      .rd_en   (rd_en && poll_b_ff),
      .rd_addr (sh_ff),
      .rd_data (rd_a)
   );

   scc_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_en && poll_b_ff),
      .wr_addr (wr_addr),
      .wr_data (conv_in.value),
      .rd_en   (rd_en && !poll_b_ff),
      .rd_addr (sh_ff),
      .rd_data (rd_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_INIT;
         prev_ff   <= 32'd0;
         poll_b_ff <= 1'b0;
         ph_ff     <= '0;
         pc_ff     <= '0;
         sh_ff     <= '0;
         sc_ff     <= '0;
         ov_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         prev_ff   <= prev_in;
         poll_b_ff <= poll_b_in;
         ph_ff     <= ph_in;
         pc_ff     <= pc_in;
         sh_ff     <= sh_in;
         sc_ff     <= sc_in;
         if (advance) begin
            ov_ff <= conv_in.valid;
         end
      end
      if (go) begin
         acc_ff  <= accepted;
         tp_ff   <= tprev;
         tc_ff   <= tcur;
         rv_ff   <= rvalid;
         rsel_ff <= poll_b_ff;
         pend_ff <= (pc_in >= CAP_C) && (sc_in == '0);
         pf_ff   <= 11'(pc_in);
         sf_ff   <= 11'(sc_in);
         st_ff   <= st_code;
      end
   end

   assign out_valid        = ov_ff;
   assign out_accepted     = acc_ff;
   assign out_prev         = tp_ff;
   assign out_cur          = tc_ff;
   assign out_read_valid   = rv_ff;
   assign out_read_value   = rv_ff ? (rsel_ff ? rd_a : rd_b) : 32'd0;
   assign out_swap_pending = pend_ff;
   assign out_poll_fill    = pf_ff;
   assign out_swap_fill    = sf_ff;
   assign out_state        = st_ff;
endmodule

FILE: hdl/scope_capture_channel.sv
// Top level of the scope capture channel.
//
// One channel of a sampling scope with two ring memories used ping-pong.
// Request channel (req_valid/req_stall) carries req_mode and req_sample_word:
// poll, bind, start, stop, clear, swap or read. Every request transaction
// produces exactly one response transaction on rsp_valid/rsp_stall with the
// status fields, the trigger pair of a poll and the value popped by a read.
// csr_valid/csr_ready write sample_type (format of the raw word); csr_ready is
// always high, write it only while the channel is idle.
// Path: two converter stages, then the ring update together with the memory
// access and result register.
// Throughput: one transaction per cycle while no response is stalled; each ring
// memory sees at most one write (poll ring) or one read (swap ring) per cycle.
// Reset: channel goes to init, previous sample to +0.0, both rings empty,
// sample_type to float. Ring contents are not cleared; no clearing pass.
// Stall: while rsp_stall holds a pending response, the whole pipeline holds
// and req_stall rises; with the output free, requests flow every cycle.
module scope_capture_channel #(
   parameter int CAPACITY = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_mode,
   input  logic [31:0] req_sample_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_command_accepted,
   output logic [31:0] rsp_trigger_previous,
   output logic [31:0] rsp_trigger_current,
   output logic [31:0] rsp_read_value,
   output logic        rsp_read_valid,
   output logic        rsp_swap_pending,
   output logic [10:0] rsp_poll_fill,
   output logic [10:0] rsp_swap_fill,
   output logic [1:0]  rsp_channel_state,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_sample_type
);
   import scc_pkg::*;

   logic         advance;
   logic [2:0]   sample_type_ff;
   conv_out_type conv;

   // advance the pipeline whenever the result register is empty or drains
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_type_ff <= SAMPLE_TYPE_RESET;
      end else if (csr_valid) begin
         sample_type_ff <= csr_sample_type;
      end
   end

   // convert the raw word ahead of the ring stage
   scc_convert u_convert (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .take        (req_valid),
      .mode        (req_mode),
      .word        (req_sample_word),
      .sample_type (sample_type_ff),
      .conv_out    (conv)
   );

   // update state and rings, access memories, hold the response
   scc_ring_ctrl #(.CAPACITY(CAPACITY)) u_ring_ctrl (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .conv_in          (conv),
      .out_valid        (rsp_valid),
      .out_accepted     (rsp_command_accepted),
      .out_prev         (rsp_trigger_previous),
      .out_cur          (rsp_trigger_current),
      .out_read_value   (rsp_read_value),
      .out_read_valid   (rsp_read_valid),
      .out_swap_pending (rsp_swap_pending),
      .out_poll_fill    (rsp_poll_fill),
      .out_swap_fill    (rsp_swap_fill),
      .out_state        (rsp_channel_state)
   );
endmodule

FILE: hdl/scc_checker.sv
// Port-level checker for the scope capture channel, with its bind.
`include "scope_capture_channel_macros.svh"

module scc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_command_accepted,
   input logic [31:0] rsp_trigger_current,
   input logic [31:0] rsp_read_value,
   input logic        rsp_read_valid,
   input logic [1:0]  rsp_channel_state
);
   import scc_pkg::*;

   // hold a stalled response
   `SCC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // drop read data when nothing was popped
   `SCC_ASSERT_NOW(a_read_zero, clock, reset, rsp_valid && !rsp_read_valid, rsp_read_value == 32'd0)

   // an accepted command never reports the init state
   `SCC_ASSERT_NOW(a_acc_state, clock, reset, rsp_valid && rsp_command_accepted, rsp_channel_state != CODE_INIT)

   // a response in init never carries a trigger sample
   `SCC_ASSERT_NOW(a_init_trig, clock, reset, rsp_valid && rsp_channel_state == CODE_INIT, rsp_trigger_current == 32'd0)
endmodule

bind scope_capture_channel scc_checker u_scc_checker (.*);
